FILE: sv/bgc_pkg.sv
// Package for the button gesture classifier.
// Holds the phase and gesture codes, the configuration struct and the reset values.
// No dependencies; every other file refers to it by scoped names.
package bgc_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned THR_W  = 16;
    localparam int unsigned IN_TDATA_W  = 40;
    localparam int unsigned OUT_TDATA_W = 8;

    localparam logic [THR_W-1:0] LONG_PRESS_RST = 16'd800;
    localparam logic [THR_W-1:0] DOUBLE_GAP_RST = 16'd250;

    // Configuration register indexes.
    localparam logic REG_LONG_PRESS = 1'b0;
    localparam logic REG_DOUBLE_GAP = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_PRESSED  = 3'd1,
        PH_LONG     = 3'd2,
        PH_SINGLE   = 3'd3,
        PH_DOUBLE   = 3'd4,
        PH_ONCE     = 3'd5,
        PH_WAITREL  = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        GEST_NONE   = 2'd0,
        GEST_SINGLE = 2'd1,
        GEST_LONG   = 2'd2,
        GEST_DOUBLE = 2'd3
    } t_gesture;

    typedef struct packed {
        logic [THR_W-1:0] long_press_ms;
        logic [THR_W-1:0] double_gap_ms;
    } t_cfg;

endpackage

FILE: sv/bgc_cfg.sv
// Configuration registers of the button gesture classifier.
// Depends on bgc_pkg for the register indexes, widths and reset values.
module bgc_cfg (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_index,
    input  logic [bgc_pkg::THR_W-1:0] i_cfg_data,
    output bgc_pkg::t_cfg             o_cfg
);

    bgc_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.long_press_ms <= bgc_pkg::LONG_PRESS_RST;
            r_cfg.double_gap_ms <= bgc_pkg::DOUBLE_GAP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bgc_pkg::REG_LONG_PRESS: begin
                    r_cfg.long_press_ms <= i_cfg_data;
                end
                bgc_pkg::REG_DOUBLE_GAP: begin
                    r_cfg.double_gap_ms <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: sv/bgc_fsm.sv
// Gesture state machine: phase, press and release timestamps, and the event decode.
// Depends on bgc_pkg for the phase and gesture enums and the configuration struct.
module bgc_fsm (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  logic                       i_level,
    input  logic [bgc_pkg::TIME_W-1:0] i_time_ms,
    input  bgc_pkg::t_cfg              i_cfg,
    output bgc_pkg::t_gesture          o_gesture
);

    bgc_pkg::t_phase             r_phase;
    bgc_pkg::t_phase             n_phase;
    logic [bgc_pkg::TIME_W-1:0]  r_press_time;
    logic [bgc_pkg::TIME_W-1:0]  n_press_time;
    logic [bgc_pkg::TIME_W-1:0]  r_release_time;
    logic [bgc_pkg::TIME_W-1:0]  n_release_time;
    logic [bgc_pkg::TIME_W-1:0]  held_ms;
    logic [bgc_pkg::TIME_W-1:0]  gap_ms;
    logic                        long_hit;
    logic                        gap_hit;

    // Differences wrap modulo 2^32, so a plain subtraction is enough.
    assign held_ms  = i_time_ms - r_press_time;
    assign gap_ms   = i_time_ms - r_release_time;
    assign long_hit = held_ms >= {{(bgc_pkg::TIME_W-bgc_pkg::THR_W){1'b0}},
                                  i_cfg.long_press_ms};
    assign gap_hit  = gap_ms >= {{(bgc_pkg::TIME_W-bgc_pkg::THR_W){1'b0}},
                                 i_cfg.double_gap_ms};

    always_comb begin
        n_phase        = r_phase;
        n_press_time   = r_press_time;
        n_release_time = r_release_time;
        case (r_phase)
            bgc_pkg::PH_IDLE: begin
                if (i_level) begin
                    n_press_time = i_time_ms;
                    n_phase      = bgc_pkg::PH_PRESSED;
                end
            end
            bgc_pkg::PH_PRESSED: begin
                if (!i_level) begin
                    n_release_time = i_time_ms;
                    n_phase        = bgc_pkg::PH_ONCE;
                end else if (long_hit) begin
                    n_phase = bgc_pkg::PH_LONG;
                end
            end
            bgc_pkg::PH_ONCE: begin
                // Any second press counts, the gap is only timed while released.
                if (i_level) begin
                    n_phase = bgc_pkg::PH_DOUBLE;
                end else if (gap_hit) begin
                    n_phase = bgc_pkg::PH_SINGLE;
                end
            end
            bgc_pkg::PH_LONG, bgc_pkg::PH_SINGLE, bgc_pkg::PH_DOUBLE: begin
                n_phase = bgc_pkg::PH_WAITREL;
            end
            bgc_pkg::PH_WAITREL: begin
                if (!i_level) begin
                    n_phase = bgc_pkg::PH_IDLE;
                end
            end
            default: begin
                n_phase = bgc_pkg::PH_IDLE;
            end
        endcase
    end

    // The event is reported on the sample that follows its detection.
    always_comb begin
        case (r_phase)
            bgc_pkg::PH_LONG:   o_gesture = bgc_pkg::GEST_LONG;
            bgc_pkg::PH_SINGLE: o_gesture = bgc_pkg::GEST_SINGLE;
            bgc_pkg::PH_DOUBLE: o_gesture = bgc_pkg::GEST_DOUBLE;
            default:            o_gesture = bgc_pkg::GEST_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= bgc_pkg::PH_IDLE;
            r_press_time   <= '0;
            r_release_time <= '0;
        end else if (i_step) begin
            r_phase        <= n_phase;
            r_press_time   <= n_press_time;
            r_release_time <= n_release_time;
        end
    end

    a_event_to_waitrel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && (o_gesture != bgc_pkg::GEST_NONE) |=> r_phase == bgc_pkg::PH_WAITREL)
        else $error("event not followed by wait-release");

    a_hold_without_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_phase) && $stable(r_press_time))
        else $error("state changed without a sample");

    a_release_from_pressed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && (r_phase == bgc_pkg::PH_PRESSED) && !i_level
        |=> r_phase == bgc_pkg::PH_ONCE && r_release_time == $past(i_time_ms))
        else $error("release not recorded");

endmodule

FILE: sv/button_gesture_classifier.sv
// Top level of the button gesture classifier: input register, state machine, result register.
// Depends on bgc_pkg, bgc_cfg and bgc_fsm.
//
//  channel   direction  ports                    word layout (low bit first)
//  s_axis    in         i_s_axis_t* / o_..ready  button_level[0], time_ms[32:1], zero pad
//  m_axis    out        o_m_axis_t* / i_..ready  gesture[1:0], zero pad
//  cfg       in         i_cfg_we/index/data      index 0 long_press_ms, 1 double_gap_ms
//
// A sample waits in the input register and is classified as it moves to the result register,
// so a word is accepted every cycle while the output is not stalled.
// The state machine updates phase and timestamps as each word advances, which sets that rate.
// Reset is synchronous and active low; it empties both stages, returns the phase to idle,
// zeroes the timestamps and loads the thresholds with their reset values.
// A stalled output holds its word; the input stage keeps taking words until both are full.
module button_gesture_classifier (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // button_level[0], time_ms[32:1], zeros[39:33]
    input  logic [bgc_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // gesture[1:0], zeros[7:2]
    output logic [bgc_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_index,
    input  logic [bgc_pkg::THR_W-1:0]       i_cfg_data
);

    bgc_pkg::t_cfg               cfg;
    bgc_pkg::t_gesture           gesture;
    logic                        r_in_valid;
    logic                        r_in_level;
    logic [bgc_pkg::TIME_W-1:0]  r_in_time;
    logic                        r_out_valid;
    bgc_pkg::t_gesture           r_out_gesture;
    logic                        advance;
    logic                        s_ready;

    assign advance = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign s_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_ready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_ready && i_s_axis_tvalid) begin
            r_in_level <= i_s_axis_tdata[0];
            r_in_time  <= i_s_axis_tdata[bgc_pkg::TIME_W:1];
        end
    end

    bgc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    bgc_fsm u_fsm (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (advance),
        .i_level   (r_in_level),
        .i_time_ms (r_in_time),
        .i_cfg     (cfg),
        .o_gesture (gesture)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_gesture <= gesture;
        end
    end

    assign o_s_axis_tready = s_ready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(bgc_pkg::OUT_TDATA_W-2){1'b0}}, r_out_gesture};

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && !r_in_valid)
        else $error("pipeline not empty after reset");

    a_advance_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_m_axis_tvalid)
        else $error("classified word lost");

    a_full_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && !i_m_axis_tready |-> !o_s_axis_tready)
        else $error("input taken while both stages are full");

endmodule
